/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

/* rtl/slf_pkg.sv */
// ----------------------------------------------------------------------------
// slf_pkg
// Types and fixed constants of the slope limiter factor block.
// ----------------------------------------------------------------------------
package slf_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned LimW     = FracBits + 1;
  localparam int unsigned DataW    = 32;
  localparam int unsigned NumW     = DataW + 1;
  localparam int unsigned ProdW    = 2 * DataW;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned MulSteps = DataW / DigitW;
  localparam int unsigned NumFaces = 3;
  localparam int unsigned NumLanes = 2 * NumFaces;
  localparam int unsigned LaneW    = $clog2(NumLanes);
  localparam int unsigned FaceW    = $clog2(NumFaces);
  localparam int unsigned CntMax   = (MulSteps > FracBits) ? MulSteps : FracBits;
  localparam int unsigned CntW     = $clog2(CntMax);
  localparam int unsigned EpsW     = 10;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned ApbW     = 32;

  localparam logic [LimW-1:0] LimOne = {1'b1, {FracBits{1'b0}}};

  // register index, taken from paddr[2]
  localparam logic RegMode = 1'b0;
  localparam logic RegEps  = 1'b1;

  typedef struct packed {
    logic signed [DataW-1:0] cell_value;
    logic signed [DataW-1:0] bound_max;
    logic signed [DataW-1:0] bound_min;
    logic signed [DataW-1:0] grad_x;
    logic signed [DataW-1:0] grad_y;
    logic signed [DataW-1:0] off_x0;
    logic signed [DataW-1:0] off_y0;
    logic signed [DataW-1:0] off_x1;
    logic signed [DataW-1:0] off_y1;
    logic signed [DataW-1:0] off_x2;
    logic signed [DataW-1:0] off_y2;
    logic                    last_of_cell;
  } in_item_t;

  typedef struct packed {
    logic [LimW-1:0] limiter;
    logic            whole_cell;
  } out_item_t;

endpackage

/* rtl/slope_limiter_factor_top.sv */
// ----------------------------------------------------------------------------
// slope_limiter_factor_top - Barth-Jespersen / maximum principle limiter factor
// A new item is taken only once the last one has left the face stages; the time per
// item is set by the 8-step radix-16 multiply and the single shared radix-2 divider
// (one quotient bit per cycle, up to three faces).
// Reset (rst_ni, async low): idle, limiter_mode = 1, delta_eps = 0, running min = one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slope_limiter_factor_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slf_pkg::AddrW-1:0]   paddr,
  input  logic [slf_pkg::ApbW-1:0]    pwdata,
  output logic [slf_pkg::ApbW-1:0]    prdata,
  output logic                        pready,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  slf_pkg::in_item_t           in_data_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output slf_pkg::out_item_t          out_data_o
);
  import slf_pkg::*;

  // Datapath overview
  //   MUL  : six lanes (gx*ox, gy*oy for each face) form |g|*|o| one radix-16
  //          digit of the offset per cycle; signs are carried aside.
  //   Then, per face, one after another:
  //   SUM  : signed sum of the two products as sign and magnitude (delta).
  //   CHK  : numerator (bound - u) on the side that delta points to, dead band test.
  //   PREP : trivial outcomes (one, zero, quotient >= one) or start the divider.
  //   DIV  : restoring division, one quotient bit per cycle, FRAC_BITS quotient bits.
  //   MIN  : fold the face factor into the item's minimum.
  //   FIN  : per-variable result, or cell minimum fold; emitted on the cell's last var.
  // The output register parts the result from the input side, so a new item
  // is taken while the last result still waits for its transfer.

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_CHK,
    ST_PREP,
    ST_DIV,
    ST_MIN,
    ST_FIN
  } state_e;

  state_e                  state_q;
  logic [CntW-1:0]         cnt_q;
  logic [FaceW-1:0]        face_q;
  logic                    mode_q;
  logic [EpsW-1:0]         eps_q;
  logic [LimW-1:0]         run_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  // item payload
  logic signed [DataW-1:0] u_q;
  logic signed [DataW-1:0] bmax_q;
  logic signed [DataW-1:0] bmin_q;
  logic                    last_q;

  // multiplier lanes
  logic [DataW-1:0]        ma_q   [NumLanes];
  logic [DataW-1:0]        mb_q   [NumLanes];
  logic [ProdW-1:0]        prod_q [NumLanes];
  logic [NumLanes-1:0]     psgn_q;

  // per-face datapath
  logic [ProdW-1:0]        dmag_q;
  logic                    dneg_q;
  logic signed [NumW-1:0]  num_q;
  logic                    db_q;
  logic [LimW-1:0]         fac_q;
  logic                    div_q;
  logic [ProdW-1:0]        rem_q;
  logic [FracBits-1:0]     quo_q;
  logic [LimW-1:0]         phi_q;

  logic                    in_fire;
  logic                    slot_free;

  function automatic logic [DataW-1:0] mag32(input logic [DataW-1:0] v);
    return v[DataW-1] ? DataW'(~v + 1'b1) : v;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port: zero wait states, byte lanes of paddr ignored.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      RegMode: prdata = ApbW'(mode_q);
      RegEps:  prdata = ApbW'(eps_q);
      default: prdata = '0;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------------------
  // Lane operands: lane 2f is gx*ox_f, lane 2f+1 is gy*oy_f.
  // ---------------------------------------------------------------------------
  logic [DataW-1:0] lane_g [NumLanes];
  logic [DataW-1:0] lane_o [NumLanes];

  always_comb begin
    lane_g[0] = in_data_i.grad_x;  lane_o[0] = in_data_i.off_x0;
    lane_g[1] = in_data_i.grad_y;  lane_o[1] = in_data_i.off_y0;
    lane_g[2] = in_data_i.grad_x;  lane_o[2] = in_data_i.off_x1;
    lane_g[3] = in_data_i.grad_y;  lane_o[3] = in_data_i.off_y1;
    lane_g[4] = in_data_i.grad_x;  lane_o[4] = in_data_i.off_x2;
    lane_g[5] = in_data_i.grad_y;  lane_o[5] = in_data_i.off_y2;
  end

  // Radix-16 shift-add: add multiplicand * digit into the upper half, shift right.
  logic [DataW+DigitW-1:0] mul_sum  [NumLanes];
  logic [ProdW-1:0]        prod_nx  [NumLanes];

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      mul_sum[l] = (DataW+DigitW)'(prod_q[l][ProdW-1:DataW])
                 + (DataW+DigitW)'(ma_q[l]) * (DataW+DigitW)'(mb_q[l][DigitW-1:0]);
      prod_nx[l] = {mul_sum[l], prod_q[l][DataW-1:DigitW]};
    end
  end

  // ---------------------------------------------------------------------------
  // Face stages.
  // ---------------------------------------------------------------------------
  logic [LaneW-1:0] lane_a;
  logic [LaneW-1:0] lane_b;
  logic [ProdW-1:0] p_a;
  logic [ProdW-1:0] p_b;
  logic             s_a;
  logic             s_b;
  logic [ProdW-1:0] sum_mag;
  logic             sum_neg;

  assign lane_a = LaneW'({face_q, 1'b0});
  assign lane_b = LaneW'({face_q, 1'b1});
  assign p_a    = prod_q[lane_a];
  assign p_b    = prod_q[lane_b];
  assign s_a    = psgn_q[lane_a];
  assign s_b    = psgn_q[lane_b];

  // Products are at most 2^62 each, so the sum of magnitudes fits.
  always_comb begin
    if (s_a == s_b) begin
      sum_mag = p_a + p_b;
      sum_neg = s_a;
    end else if (p_a >= p_b) begin
      sum_mag = p_a - p_b;
      sum_neg = s_a;
    end else begin
      sum_mag = p_b - p_a;
      sum_neg = s_b;
    end
  end

  logic signed [DataW-1:0] bound_sel;
  logic signed [NumW-1:0]  num_d;
  logic [ProdW-1:0]        eps_sh;

  assign bound_sel = dneg_q ? bmin_q : bmax_q;
  assign num_d     = NumW'(bound_sel) - NumW'(u_q);
  assign eps_sh    = ProdW'(eps_q) << FracBits;

  logic            nneg;
  logic [NumW-1:0] nmag;
  logic [ProdW-1:0] rini;
  logic            prep_one;
  logic            prep_zero;

  assign nneg      = num_q[NumW-1];
  assign nmag      = nneg ? NumW'(~num_q + 1'b1) : num_q;
  assign rini      = ProdW'(nmag) << FracBits;
  // dead band and a quotient of at least one both give one
  assign prep_one  = db_q || ((nmag != '0) && (nneg == dneg_q) && (rini >= dmag_q));
  assign prep_zero = !db_q && ((nmag == '0) || (nneg != dneg_q));

  logic [ProdW:0]   rem_sh;
  logic             div_ge;
  logic [ProdW-1:0] rem_nx;

  assign rem_sh = {rem_q, 1'b0};
  assign div_ge = rem_sh >= {1'b0, dmag_q};
  assign rem_nx = div_ge ? ProdW'(rem_sh - {1'b0, dmag_q}) : rem_sh[ProdW-1:0];

  logic [LimW-1:0] face_k;
  logic [LimW-1:0] phi_nx;

  assign face_k = div_q ? {1'b0, quo_q} : fac_q;
  assign phi_nx = (face_k < phi_q) ? face_k : phi_q;

  logic [LimW-1:0] fold;
  logic            emit;

  assign fold = (phi_q < run_q) ? phi_q : run_q;
  assign emit = !mode_q || last_q;

  // ---------------------------------------------------------------------------
  // Datapath registers (no reset).
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      u_q    <= in_data_i.cell_value;
      bmax_q <= in_data_i.bound_max;
      bmin_q <= in_data_i.bound_min;
      last_q <= in_data_i.last_of_cell;
      phi_q  <= LimOne;
      for (int l = 0; l < NumLanes; l++) begin
        ma_q[l]   <= mag32(lane_g[l]);
        mb_q[l]   <= mag32(lane_o[l]);
        prod_q[l] <= '0;
        psgn_q[l] <= lane_g[l][DataW-1] ^ lane_o[l][DataW-1];
      end
    end else begin
      case (state_q)
        ST_MUL: begin
          for (int l = 0; l < NumLanes; l++) begin
            mb_q[l]   <= mb_q[l] >> DigitW;
            prod_q[l] <= prod_nx[l];
          end
        end
        ST_SUM: begin
          dmag_q <= sum_mag;
          dneg_q <= sum_neg;
        end
        ST_CHK: begin
          num_q <= num_d;
          db_q  <= (dmag_q <= eps_sh);
        end
        ST_PREP: begin
          fac_q <= prep_one ? LimOne : '0;
          div_q <= !prep_one && !prep_zero;
          rem_q <= rini;
          quo_q <= '0;
        end
        ST_DIV: begin
          rem_q <= rem_nx;
          quo_q <= {quo_q[FracBits-2:0], div_ge};
        end
        ST_MIN: begin
          phi_q <= phi_nx;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, configuration registers, running minimum, output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      face_q      <= '0;
      mode_q      <= 1'b1;
      eps_q       <= '0;
      run_q       <= LimOne;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          RegMode: mode_q <= pwdata[0];
          RegEps:  eps_q  <= pwdata[EpsW-1:0];
          default: ;
        endcase
      end

      // a result loaded in ST_FIN this cycle takes the register instead
      if (out_ready_i && !(state_q == ST_FIN && emit)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cnt_q   <= CntW'(MulSteps - 1);
            face_q  <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM:  state_q <= ST_CHK;
        ST_CHK:  state_q <= ST_PREP;
        ST_PREP: begin
          if (prep_one || prep_zero) begin
            state_q <= ST_MIN;
          end else begin
            cnt_q   <= CntW'(FracBits - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_MIN;
          end
        end
        ST_MIN: begin
          if (face_q == FaceW'(NumFaces - 1)) begin
            state_q <= ST_FIN;
          end else begin
            face_q  <= face_q + 1'b1;
            state_q <= ST_SUM;
          end
        end
        ST_FIN: begin
          if (!emit) begin
            // per-cell mode, not the last variable: fold only
            run_q   <= fold;
            state_q <= ST_IDLE;
          end else if (slot_free) begin
            out_valid_q      <= 1'b1;
            out_q.limiter    <= mode_q ? fold : phi_q;
            out_q.whole_cell <= mode_q;
            if (mode_q) begin
              run_q <= LimOne;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // divider partial remainder stays below the divisor
  `ASSERT_IMPL(a_div_rem, clk_i, rst_ni, state_q == ST_DIV, rem_q < dmag_q)
  // folding a face never raises the item's minimum
  `ASSERT_NEXT(a_phi_fold, clk_i, rst_ni, state_q == ST_MIN, phi_q <= $past(phi_q))
  // the running cell minimum never exceeds one
  `ASSERT_IMPL(a_run_max, clk_i, rst_ni, 1'b1, run_q <= LimOne)
  // a whole-cell result only comes out in per-cell mode
  `ASSERT_IMPL(a_whole_mode, clk_i, rst_ni, out_valid_o && out_data_o.whole_cell, mode_q)

endmodule

/* tb/tb_slope_limiter_factor_top.sv */
// ----------------------------------------------------------------------------
// tb_slope_limiter_factor_top
// Self-checking bench for the slope limiter factor block. Items go in over a
// valid/ready channel with random gaps. Results come back over a second
// channel with random and long stalls. A predictor in the bench computes the
// exact per-face ratio, the clamp, the face minimum and the per-cell running
// minimum, and checks every result in order. Directed items cover the
// extremes, the dead band and a mode change mid-cell. Random phases sweep
// both modes and several dead band settings.
// ----------------------------------------------------------------------------
module tb_slope_limiter_factor_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slf_pkg::*;

  // limiter_mode encodings
  localparam logic ModePerVar  = 1'b0;  // one result per variable
  localparam logic ModePerCell = 1'b1;  // running minimum, result on last var

  localparam int DrainCycles = 150;  // above the slowest item, with margin
  localparam int HoldCycles  = 400;  // long receiver stall

  localparam logic signed [DataW-1:0] One   = 32'sh0001_0000;
  localparam logic signed [DataW-1:0] Min32 = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] Max32 = 32'sh7FFF_FFFF;

  // --------------------------------------------------------------------------
  // DUT connections
  // --------------------------------------------------------------------------
  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [AddrW-1:0]  paddr   = '0;
  logic [ApbW-1:0]   pwdata  = '0;
  logic [ApbW-1:0]   prdata;
  logic              pready;
  logic              var_valid = 1'b0;
  logic              in_ready_o;
  in_item_t          var_data  = '0;
  logic              out_valid_o;
  logic              phi_ready = 1'b0;
  out_item_t         out_data_o;

  slope_limiter_factor_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (var_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (var_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (phi_ready),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  in_item_t        vars_to_send[$];   // items waiting for the driver
  out_item_t       limiters_due[$];   // predicted results, oldest first
  logic            mode_cfg = ModePerCell;  // bench copy of limiter_mode
  logic [EpsW-1:0] eps_cfg  = '0;           // bench copy of delta_eps
  logic [LimW-1:0] cell_min = LimOne;       // bench copy of the running min
  int              errors   = 0;
  int              xfers_in = 0;
  int              in_gap   = 0;
  int              out_gap  = 0;
  int              calm_left[2] = '{0, 0};  // 0: sender, 1: receiver
  logic            hold_results = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Exact factor of one face: delta carries 32 fraction bits, the ratio is
  // truncated toward zero and clamped to [0, one].
  function automatic logic [LimW-1:0] face_phi(in_item_t it,
                                               logic signed [DataW-1:0] ox,
                                               logic signed [DataW-1:0] oy);
    longint             p1, p2, num;
    logic signed [65:0] delta;
    logic [65:0]        dmag;
    logic [127:0]       r, q;
    logic               dneg;
    p1 = longint'($signed(it.grad_x)) * longint'($signed(ox));
    p2 = longint'($signed(it.grad_y)) * longint'($signed(oy));
    // products reach 2^62 each, so the sum gets two guard bits
    delta = {{2{p1[63]}}, p1} + {{2{p2[63]}}, p2};
    dneg  = delta[65];
    dmag  = dneg ? -delta : delta;
    // dead band, inclusive; eps in input LSBs
    if (dmag <= (66'(eps_cfg) << FracBits)) return LimOne;
    num = (dneg ? longint'($signed(it.bound_min)) : longint'($signed(it.bound_max)))
        - longint'($signed(it.cell_value));
    // zero or opposite-sign headroom clamps to zero
    if (num == 0 || ((num < 0) != dneg)) return '0;
    r = 128'(num < 0 ? -num : num) << FracBits;
    if (r >= 128'(dmag)) return LimOne;
    q = (r << FracBits) / 128'(dmag);
    return q[LimW-1:0];
  endfunction

  // Fold one accepted variable into the prediction.
  task automatic fold_variable(in_item_t it);
    logic [LimW-1:0] phi, k;
    phi = face_phi(it, it.off_x0, it.off_y0);
    k = face_phi(it, it.off_x1, it.off_y1);
    if (k < phi) phi = k;
    k = face_phi(it, it.off_x2, it.off_y2);
    if (k < phi) phi = k;
    if (mode_cfg == ModePerVar) begin
      // last_of_cell is ignored and the running min is left alone
      limiters_due.push_back('{limiter: phi, whole_cell: 1'b0});
    end else begin
      if (phi < cell_min) cell_min = phi;
      if (it.last_of_cell) begin
        limiters_due.push_back('{limiter: cell_min, whole_cell: 1'b1});
        cell_min = LimOne;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string what);
    errors++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (limiters_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected result limiter %h whole_cell %b",
                              got.limiter, got.whole_cell));
      return;
    end
    want = limiters_due.pop_front();
    if (got.limiter !== want.limiter)
      flag_mismatch($sformatf("limiter %h, expected %h", got.limiter, want.limiter));
    if (got.whole_cell !== want.whole_cell)
      flag_mismatch($sformatf("whole_cell %b, expected %b", got.whole_cell,
                              want.whole_cell));
  endtask

  // --------------------------------------------------------------------------
  // Idle cycles before each transfer. Now and then a calm stretch with no
  // idling at all, so back-to-back transfers are covered as well.
  // --------------------------------------------------------------------------
  function automatic int draw_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left[side] = $urandom_range(10, 40);
    return $urandom_range(0, 10);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued items; valid holds with stable data until the
  // transfer, then waits its drawn gap before the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_valid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (var_valid && in_ready_o) begin
        fold_variable(var_data);
        xfers_in++;
      end
      // slot is free unless an offered item is still pending
      if (!var_valid || in_ready_o) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          var_valid <= 1'b0;
        end else if (vars_to_send.size() != 0) begin
          var_data  <= vars_to_send.pop_front();
          var_valid <= 1'b1;
          in_gap    <= draw_wait(0);
        end else begin
          var_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transfer, then stalls for a drawn number of
  // cycles. hold_results forces a long stall on top of that.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : mon
    int nxt;
    if (!rst_ni) begin
      phi_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      nxt = out_gap;
      if (out_valid_o && phi_ready) begin
        check_result(out_data_o);
        nxt = draw_wait(1);
      end
      if (hold_results) begin
        phi_ready <= 1'b0;
        out_gap   <= nxt;
      end else if (nxt != 0) begin
        phi_ready <= 1'b0;
        out_gap   <= nxt - 1;
      end else begin
        phi_ready <= 1'b1;
        out_gap   <= 0;
      end
    end
  end

  // Long receiver hold-off, in the first random per-variable phase:
  // results back up, the block fills and stalls its input.
  initial begin
    wait (xfers_in >= 120);
    @(posedge clk_i);
    hold_results <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_results <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Configuration port: setup + access write, then a readback.
  // --------------------------------------------------------------------------
  task automatic write_reg(logic idx, logic [ApbW-1:0] value);
    logic [ApbW-1:0] want, got;
    want = (idx == RegMode) ? ApbW'(value[0]) : ApbW'(value[EpsW-1:0]);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);  // register takes the value at this edge
    if (idx == RegMode) mode_cfg = value[0];
    else eps_cfg = value[EpsW-1:0];
    // straight into the read setup phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      flag_mismatch($sformatf("register %0d reads %h, expected %h", idx, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t cell_var(logic signed [DataW-1:0] u, bmax, bmin, gx, gy,
                                        x0, y0, x1, y1, x2, y2, logic last);
    return {u, bmax, bmin, gx, gy, x0, y0, x1, y1, x2, y2, last};
  endfunction

  // signed value in [-2^n, 2^n - 1]
  function automatic logic signed [DataW-1:0] rand_q16(int n);
    logic signed [DataW-1:0] v;
    v = $urandom;
    return v >>> (31 - n);
  endfunction

  // Mostly physical items: bounds around the cell value, gradients and
  // offsets at random scales so ratios land on both sides of one and deltas
  // straddle the dead band. The rest is raw noise over every bit.
  function automatic in_item_t draw_item(logic last);
    in_item_t                it;
    logic signed [DataW-1:0] t;
    int                      gb, ob, db;
    if ($urandom_range(0, 9) == 0) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom)};
      return it;
    end
    gb = $urandom_range(0, 20);
    ob = $urandom_range(0, 18);
    db = $urandom_range(0, 22);
    it.cell_value = rand_q16($urandom_range(4, 31));
    it.bound_max  = it.cell_value + $urandom_range(0, (1 << db) - 1);
    it.bound_min  = it.cell_value - $urandom_range(0, (1 << db) - 1);
    if ($urandom_range(0, 7) == 0) begin
      // bounds on the wrong side of the cell value
      t            = it.bound_max;
      it.bound_max = it.bound_min;
      it.bound_min = t;
    end
    it.grad_x = rand_q16(gb);
    it.grad_y = rand_q16(gb);
    it.off_x0 = rand_q16(ob);
    it.off_y0 = rand_q16(ob);
    it.off_x1 = rand_q16(ob);
    it.off_y1 = rand_q16(ob);
    it.off_x2 = rand_q16(ob);
    it.off_y2 = rand_q16(ob);
    if ($urandom_range(0, 7) == 0) begin
      it.off_x1 = '0;
      it.off_y1 = '0;
    end
    it.last_of_cell = last;
    return it;
  endfunction

  // n random items; in per-cell phases grouped into cells of 1 to 6 vars
  task automatic queue_random(int n, logic by_cell);
    int left, i;
    left = 0;
    for (i = 0; i < n || (by_cell && left != 0); i++) begin
      if (left == 0) left = $urandom_range(1, 6);
      left--;
      vars_to_send.push_back(draw_item(by_cell ? (left == 0) : 1'($urandom)));
    end
  endtask

  // Wait for the block to go quiet: queue empty, nothing in flight on the
  // input, every predicted result in. Then cover items that give no result.
  task automatic drain_all();
    while (vars_to_send.size() != 0 || var_valid || limiters_due.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(logic mode, logic [ApbW-1:0] eps, int n);
    write_reg(RegMode, ApbW'(mode));
    write_reg(RegEps, eps);
    @(negedge clk_i);
    queue_random(n, mode == ModePerCell);
    drain_all();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Per-variable, no dead band; junk above the mode bit must be dropped.
    write_reg(RegMode, 32'hFFFF_FFFE);
    write_reg(RegEps, 32'd0);
    @(negedge clk_i);
    // zero delta everywhere: one
    vars_to_send.push_back(cell_var(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    // all fields at the negative extreme: largest delta, no headroom
    vars_to_send.push_back(cell_var(Min32, Min32, Min32, Min32, Min32, Min32, Min32,
                                    Min32, Min32, Min32, Min32, 1'b0));
    // all at the positive extreme, last flag ignored in this mode
    vars_to_send.push_back(cell_var(Max32, Max32, Max32, Max32, Max32, Max32, Max32,
                                    Max32, Max32, Max32, Max32, 1'b1));
    // exact half
    vars_to_send.push_back(cell_var(0, 32'sh8000, -32'sh8000, One, 0, One, 0,
                                    0, 0, 0, 0, 1'b0));
    // negative delta against the minimum: a quarter
    vars_to_send.push_back(cell_var(0, One, -32'sh4000, -One, 0, One, 0,
                                    0, 0, 0, 0, 1'b0));
    // headroom of the wrong sign: zero
    vars_to_send.push_back(cell_var(One, 0, -One, One, 0, One, 0, 0, 0, 0, 0, 1'b0));
    // ratio above one clamps to one
    vars_to_send.push_back(cell_var(0, 2 * One, 0, One, 0, One, 0, 0, 0, 0, 0, 1'b0));
    // smallest nonzero delta
    vars_to_send.push_back(cell_var(0, 1, -1, 1, 0, 1, 0, 0, 0, 0, 0, 1'b0));
    // truncation of one third
    vars_to_send.push_back(cell_var(0, 1, 0, 3, 0, One, 0, 0, 0, 0, 0, 1'b0));
    // products cancel to a zero delta despite no headroom
    vars_to_send.push_back(cell_var(0, 0, 0, One, One, One, -One, 0, 0, 0, 0, 1'b0));
    // three faces, the minimum comes from the last
    vars_to_send.push_back(cell_var(0, One, -One, One, One, 32'sh8000, 32'sh8000,
                                    2 * One, 0, 0, -4 * One, 1'b0));
    // widest headroom against a tiny delta
    vars_to_send.push_back(cell_var(Min32, Max32, Min32, 1, 0, 1, 0, 0, 0, 0, 0, 1'b0));
    // widest headroom against the widest delta
    vars_to_send.push_back(cell_var(Min32, Max32, Min32, Min32, Min32, Min32, Min32,
                                    0, 0, 0, 0, 1'b0));
    // large negative delta against the minimum
    vars_to_send.push_back(cell_var(Max32, Max32, Min32, Min32, 0, Max32, 0,
                                    0, 0, 0, 0, 1'b1));
    drain_all();

    // Per-cell, widest dead band; junk above the eps field.
    write_reg(RegMode, 32'd1);
    write_reg(RegEps, 32'hFFFF_FFFF);
    @(negedge clk_i);
    // delta exactly at the band edge, both signs: one
    vars_to_send.push_back(cell_var(0, 0, 0, 1023, 0, One, 0, 0, 0, 0, 0, 1'b0));
    vars_to_send.push_back(cell_var(0, 0, 0, -1023, 0, One, 0, 0, 0, 0, 0, 1'b1));
    // just past the edge: half, then one, then three quarters
    vars_to_send.push_back(cell_var(0, 512, 0, 1024, 0, One, 0, 0, 0, 0, 0, 1'b0));
    vars_to_send.push_back(cell_var(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    vars_to_send.push_back(cell_var(0, 0, -32'sh300, -1024, 0, One, 0,
                                    0, 0, 0, 0, 1'b1));
    // cell left open across the mode changes that follow
    vars_to_send.push_back(cell_var(0, 32'sh2000, 0, One, 0, One, 0, 0, 0, 0, 0, 1'b0));
    drain_all();

    // Per-variable random; the long receiver stall falls in here.
    run_phase(ModePerVar, 32'd0, 250);

    // Back to per-cell: the open cell closes with its old minimum.
    write_reg(RegMode, 32'd1);
    @(negedge clk_i);
    vars_to_send.push_back(cell_var(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    drain_all();
    run_phase(ModePerCell, 32'd0, 180);

    run_phase(ModePerVar, ApbW'($urandom_range(1, 1022)), 100);
    run_phase(ModePerCell, ApbW'($urandom_range(1, 1022)), 150);
    run_phase(ModePerVar, 32'h3FF, 50);

    if (errors == 0 && limiters_due.size() == 0) begin
      $display("slope_limiter_factor_top verification clean");
    end else begin
      $display("slope_limiter_factor_top verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("slope_limiter_factor_top verification failed");
    $finish;
  end

endmodule
